// ----- design/phcv_pkg.sv -----
// Shared types and constants for the packet header parser and checksum checker.
package phcv_pkg;

   localparam int unsigned CountWidth  = 10;
   localparam int unsigned HeaderBytes = 8;
   localparam logic [15:0] SumAllOnes  = 16'hffff;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  version;
      logic [1:0]  packet_type;
      logic [9:0]  body_length;
      logic [15:0] received_checksum;
      logic [31:0] sequence_number;
      logic        checksum_ok;
      logic        runt;
      logic        oversize;
   } rsp_payload_type;

endpackage

// ----- design/packet_header_parse_checksum_verify_top.sv -----
// Datagram header capture and ones complement checksum check, one byte per word.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_data (data_byte, last_byte)
//   rsp      out        rsp_valid / rsp_ready   rsp_data (header fields and verdict)
//
// One byte per cycle while no held result stalls a last byte. A byte waits in the input register and its
// result, if it is the last byte, is written into the output register when that byte advances.
// The checksum update is one 16-bit end-around-carry add per pair of bytes.
// Synchronous active-high reset clears the running state and both valid flags.
// A held result only stalls the input when the byte waiting in the input register is a last.
module packet_header_parse_checksum_verify_top
   import phcv_pkg::*;
#(
   parameter int unsigned MAX_PACKET_BYTES = 512
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam logic [CountWidth-1:0] MaxBytes = CountWidth'(MAX_PACKET_BYTES);
   localparam logic [CountWidth-1:0] HdrBytes = CountWidth'(HeaderBytes);

   logic                  in_valid_ff;
   req_payload_type       in_data_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_data_ff;

   logic [CountWidth-1:0] cnt_ff,  cnt_in;
   logic [15:0]           sum_ff,  sum_in;
   logic [7:0]            pend_ff, pend_in;
   logic [7:0][7:0]       hdr_ff,  hdr_in;
   logic                  ovf_ff,  ovf_in;

   logic                  advance;
   logic                  take_byte;
   logic [15:0]           operand;
   logic [16:0]           raw_sum;
   logic [15:0]           add_res;
   logic [63:0]           hdr_flat;
   rsp_payload_type       rsp_next;

   assign advance   = in_valid_ff && (!in_data_ff.last_byte || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take_byte = cnt_ff < MaxBytes;

   always_comb begin
      if (take_byte && cnt_ff[0]) begin
         operand = {pend_ff, in_data_ff.data_byte};
      end else if (take_byte) begin
         operand = {in_data_ff.data_byte, 8'h00};
      end else if (cnt_ff[0]) begin
         operand = {pend_ff, 8'h00};
      end else begin
         operand = 16'h0000;
      end
      raw_sum = {1'b0, sum_ff} + {1'b0, operand};
      add_res = raw_sum[15:0] + {15'd0, raw_sum[16]};
   end

   always_comb begin
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      pend_in = pend_ff;
      hdr_in  = hdr_ff;
      ovf_in  = ovf_ff;
      if (take_byte) begin
         if (cnt_ff < HdrBytes) begin
            hdr_in[3'd7 - cnt_ff[2:0]] = in_data_ff.data_byte;
         end
         if (cnt_ff[0]) begin
            sum_in = add_res;
         end else begin
            pend_in = in_data_ff.data_byte;
         end
         cnt_in = cnt_ff + CountWidth'(1);
      end else begin
         ovf_in = 1'b1;
      end

      hdr_flat                   = hdr_in;
      rsp_next.version           = hdr_flat[63:60];
      rsp_next.packet_type       = hdr_flat[59:58];
      rsp_next.body_length       = hdr_flat[57:48];
      rsp_next.received_checksum = hdr_flat[47:32];
      rsp_next.sequence_number   = hdr_flat[31:0];
      rsp_next.checksum_ok       = add_res == SumAllOnes;
      rsp_next.runt              = cnt_in < HdrBytes;
      rsp_next.oversize          = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         pend_ff      <= '0;
         hdr_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance && in_data_ff.last_byte) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            if (in_data_ff.last_byte) begin
               cnt_ff  <= '0;
               sum_ff  <= '0;
               pend_ff <= '0;
               hdr_ff  <= '0;
               ovf_ff  <= 1'b0;
            end else begin
               cnt_ff  <= cnt_in;
               sum_ff  <= sum_in;
               pend_ff <= pend_in;
               hdr_ff  <= hdr_in;
               ovf_ff  <= ovf_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance && in_data_ff.last_byte) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MaxBytes)
      else $error("byte count beyond maximum");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.last_byte |=> cnt_ff == '0 && sum_ff == '0 && !ovf_ff)
      else $error("state not cleared after last byte");

   a_runt_excl_oversize: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.oversize |-> !rsp_data_ff.runt)
      else $error("runt and oversize together");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("input word lost while stalled");

   a_ovf_only_at_max: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> cnt_ff == MaxBytes)
      else $error("overflow flagged below maximum");

endmodule
